FILE: rtl/gdspi_pkg.sv
package gdspi_pkg;

	// Request codes on the operation field
	typedef enum logic [1:0] {
		OP_NONE  = 2'd0,
		OP_READ  = 2'd1,
		OP_WRITE = 2'd2
	} gdspi_op_t;

	// Serial engine phases
	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_HIGH = 2'd1,
		PH_LOW  = 2'd2,
		PH_GAP  = 2'd3
	} gdspi_phase_t;

	localparam logic [7:0]  HALF_PERIOD_RESET = 8'd10;
	localparam logic [7:0]  MIN_LOW_TICKS     = 8'd3;
	localparam logic [31:0] READ_CMD_BITS     = 32'h0000_807F;
	localparam logic [31:0] READ_CMD_MARK     = 32'h0000_8000;
	localparam logic [31:0] ALL_ONES_WORD     = 32'hFFFF_FFFF;

	// One tick of request and pin input
	typedef struct packed {
		logic [1:0]  operation;
		logic [3:0]  reg_addr;
		logic [10:0] write_data;
		logic        miso;
	} gdspi_item_t;

	// Pin levels and status of one tick
	typedef struct packed {
		logic        sck;
		logic        mosi;
		logic        cs_n;
		logic        busy_res;
		logic        done_res;
		logic [15:0] read_data;
	} gdspi_res_t;

endpackage

FILE: rtl/gate_driver_spi_register_master_top.sv
// Accepted words pass the input register, the engine and the result register.
// Throughput: one word per cycle; the tick engine steps once per result loaded.
// Stalls from the output side hold the input register and the engine.
// Reset: engine idle, engine state zero, valid flags low, half period 10 ticks.
module gate_driver_spi_register_master_top import gdspi_pkg::*; #(
	parameter int FRAME_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  operation,
	input  logic [3:0]  reg_addr,
	input  logic [10:0] write_data,
	input  logic        miso,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        sck,
	output logic        mosi,
	output logic        cs_n,
	output logic        busy_res,
	output logic        done_res,
	output logic [15:0] read_data
);

	logic [7:0]  hp_q;
	gdspi_item_t item_s1;
	logic        valid_s1;
	gdspi_res_t  res_c;
	gdspi_res_t  res_q;
	logic        out_valid_q;
	logic        advance;
	logic        take;

	// Half period register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hp_q <= HALF_PERIOD_RESET;
		end else if (cfg_we) begin
			hp_q <= cfg_wdata;
		end
	end

	// Handshake: step the engine when the result register is free or draining
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign take     = in_valid && !in_stall;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= '{operation: operation, reg_addr: reg_addr,
				write_data: write_data, miso: miso};
		end
	end

	gdspi_core #(
		.FRAME_BITS(FRAME_BITS)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step_en    (advance),
		.half_period(hp_q),
		.item       (item_s1),
		.res        (res_c)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_c;
		end
	end

	assign out_valid = out_valid_q;
	assign sck       = res_q.sck;
	assign mosi      = res_q.mosi;
	assign cs_n      = res_q.cs_n;
	assign busy_res  = res_q.busy_res;
	assign done_res  = res_q.done_res;
	assign read_data = res_q.read_data;

endmodule

FILE: rtl/gdspi_core.sv
module gdspi_core import gdspi_pkg::*; #(
	parameter int FRAME_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step_en,
	input  logic [7:0]  half_period,
	input  gdspi_item_t item,
	output gdspi_res_t  res
);

	localparam int FB  = FRAME_BITS;
	localparam int BCW = $clog2(FRAME_BITS + 1);

	gdspi_phase_t   phase_q, phase_d;
	logic [7:0]     tick_q, tick_d;
	logic [BCW-1:0] bit_q, bit_d;
	logic [FB-1:0]  tx_q, tx_d;
	logic [FB-1:0]  rx_q, rx_d;
	logic [1:0]     samp_q, samp_d;
	logic           pend_q, pend_d;
	logic [15:0]    last_q, last_d;
	logic           capt_q, capt_d;

	logic [7:0]  high_len;
	logic [7:0]  low_len;
	logic        vote;
	logic        done;
	logic        shifting;
	logic [31:0] cmd_word;
	logic [31:0] wr_word;

	assign high_len = (half_period == 8'd0) ? 8'd1 : half_period;
	assign low_len  = (half_period < MIN_LOW_TICKS) ? MIN_LOW_TICKS : half_period;
	assign vote     = (samp_q[1] & samp_q[0]) | (samp_q[1] & item.miso)
			| (samp_q[0] & item.miso);
	assign cmd_word = READ_CMD_MARK | READ_CMD_BITS | {17'd0, item.reg_addr, 11'd0};
	assign wr_word  = {17'd0, item.reg_addr, item.write_data};

	// Next state for one tick
	always_comb begin
		phase_d = phase_q;
		tick_d  = tick_q;
		bit_d   = bit_q;
		tx_d    = tx_q;
		rx_d    = rx_q;
		samp_d  = samp_q;
		pend_d  = pend_q;
		last_d  = last_q;
		capt_d  = capt_q;
		done    = 1'b0;
		case (phase_q)
			PH_IDLE: begin
				case (item.operation)
					OP_WRITE: begin
						pend_d  = 1'b0;
						tx_d    = FB'(wr_word);
						rx_d    = '0;
						bit_d   = '0;
						capt_d  = 1'b0;
						phase_d = PH_HIGH;
						tick_d  = 8'd1;
					end
					OP_READ: begin
						rx_d    = '0;
						bit_d   = '0;
						phase_d = PH_HIGH;
						tick_d  = 8'd1;
						if (item.reg_addr != 4'd0) begin
							pend_d = 1'b1;
							tx_d   = FB'(cmd_word);
							capt_d = 1'b0;
						end else begin
							pend_d = 1'b0;
							tx_d   = FB'(ALL_ONES_WORD);
							capt_d = 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
			PH_HIGH: begin
				if (tick_q >= high_len) begin
					phase_d = PH_LOW;
					tick_d  = 8'd1;
				end else begin
					tick_d = tick_q + 8'd1;
				end
			end
			PH_LOW: begin
				// two samples, then vote with the third
				if (tick_q < MIN_LOW_TICKS) begin
					samp_d = {samp_q[0], item.miso};
				end else if (tick_q == MIN_LOW_TICKS) begin
					rx_d = {rx_q[FB-2:0], vote};
				end
				if (tick_q >= low_len) begin
					bit_d = bit_q + BCW'(1);
					tx_d  = {tx_q[FB-2:0], 1'b0};
					if (bit_d >= BCW'(FRAME_BITS)) begin
						if (capt_q) begin
							last_d = 16'(rx_d);
						end
						capt_d = 1'b0;
						tick_d = 8'd1;
						if (pend_q) begin
							pend_d  = 1'b0;
							phase_d = PH_GAP;
						end else begin
							phase_d = PH_IDLE;
							tick_d  = 8'd0;
							done    = 1'b1;
						end
					end else begin
						phase_d = PH_HIGH;
						tick_d  = 8'd1;
					end
				end else begin
					tick_d = tick_q + 8'd1;
				end
			end
			PH_GAP: begin
				// chip select high, then the all-ones read frame
				if (tick_q >= high_len) begin
					tx_d    = FB'(ALL_ONES_WORD);
					rx_d    = '0;
					bit_d   = '0;
					capt_d  = 1'b1;
					phase_d = PH_HIGH;
					tick_d  = 8'd1;
				end else begin
					tick_d = tick_q + 8'd1;
				end
			end
			default: begin
				phase_d = PH_IDLE;
				tick_d  = 8'd0;
			end
		endcase
	end

	// Pin levels after the update
	assign shifting      = (phase_d == PH_HIGH) || (phase_d == PH_LOW);
	assign res.sck       = (phase_d == PH_HIGH);
	assign res.mosi      = shifting ? tx_d[FB-1] : 1'b0;
	assign res.cs_n      = !shifting;
	assign res.busy_res  = (phase_d != PH_IDLE);
	assign res.done_res  = done;
	assign res.read_data = last_d;

	// Engine state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			tick_q  <= '0;
			bit_q   <= '0;
			tx_q    <= '0;
			rx_q    <= '0;
			samp_q  <= '0;
			pend_q  <= 1'b0;
			last_q  <= '0;
			capt_q  <= 1'b0;
		end else if (step_en) begin
			phase_q <= phase_d;
			tick_q  <= tick_d;
			bit_q   <= bit_d;
			tx_q    <= tx_d;
			rx_q    <= rx_d;
			samp_q  <= samp_d;
			pend_q  <= pend_d;
			last_q  <= last_d;
			capt_q  <= capt_d;
		end
	end

endmodule

FILE: dv/gdspi_pin_checker.sv
`timescale 1ns / 100ps

// Watches both channels, runs its own tick engine on every accepted input word
// and compares each result word against the oldest predicted pin word.
module gdspi_pin_checker import gdspi_pkg::*; #(
	parameter int FRAME_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [1:0]  operation,
	input  logic [3:0]  reg_addr,
	input  logic [10:0] write_data,
	input  logic        miso,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic        sck,
	input  logic        mosi,
	input  logic        cs_n,
	input  logic        busy_res,
	input  logic        done_res,
	input  logic [15:0] read_data,
	output int          fail_count = 0,
	output int          pending = 0,
	output logic        engine_busy = 1'b0
);

	localparam logic [31:0] FRAME_MASK = (FRAME_BITS >= 32) ? 32'hFFFF_FFFF :
		((32'h1 << FRAME_BITS) - 32'h1);

	// Predicted engine state
	gdspi_phase_t eng_phase = PH_IDLE;
	int           tick_cnt = 0;
	int           bit_cnt = 0;
	logic [31:0]  tx_word = '0;
	logic [31:0]  rx_word = '0;
	logic [1:0]   miso_hist = '0;
	logic         read_after_cmd = 1'b0;
	logic         keep_reply = 1'b0;
	logic [15:0]  reply_word = '0;
	logic [7:0]   half_period = HALF_PERIOD_RESET;

	gdspi_res_t   expected_pins[$];
	int           mismatch_total = 0;
	int           word_index = 0;

	function automatic int high_ticks();
		return (half_period == 8'd0) ? 1 : int'(half_period);
	endfunction

	// low phase never shorter than the three MISO samples
	function automatic int low_ticks();
		return (half_period < MIN_LOW_TICKS) ? int'(MIN_LOW_TICKS) : int'(half_period);
	endfunction

	function automatic void load_frame(logic [31:0] word, logic keep);
		tx_word = word & FRAME_MASK;
		rx_word = '0;
		bit_cnt = 0;
		keep_reply = keep;
		eng_phase = PH_HIGH;
		tick_cnt = 1;
	endfunction

	// One tick of the serial engine; returns the pin word of that tick
	function automatic gdspi_res_t step_engine(gdspi_item_t it);
		gdspi_res_t r;
		logic       done;
		logic       vote;
		logic       shifting;
		done = 1'b0;
		case (eng_phase)
			PH_IDLE: begin
				if (it.operation == OP_WRITE) begin
					read_after_cmd = 1'b0;
					load_frame({17'd0, it.reg_addr, it.write_data}, 1'b0);
				end else if (it.operation == OP_READ) begin
					if (it.reg_addr != 4'd0) begin
						// command frame first, then the all-ones frame
						read_after_cmd = 1'b1;
						load_frame(READ_CMD_MARK | ({28'd0, it.reg_addr} << 11) | READ_CMD_BITS,
							1'b0);
					end else begin
						read_after_cmd = 1'b0;
						load_frame(ALL_ONES_WORD, 1'b1);
					end
				end
			end
			PH_HIGH: begin
				if (tick_cnt >= high_ticks()) begin
					eng_phase = PH_LOW;
					tick_cnt = 1;
				end else begin
					tick_cnt++;
				end
			end
			PH_LOW: begin
				// two samples, then vote with the third
				if (tick_cnt < int'(MIN_LOW_TICKS)) begin
					miso_hist = {miso_hist[0], it.miso};
				end else if (tick_cnt == int'(MIN_LOW_TICKS)) begin
					vote = (miso_hist[1] & miso_hist[0]) | (miso_hist[1] & it.miso) |
						(miso_hist[0] & it.miso);
					rx_word = ((rx_word << 1) | {31'd0, vote}) & FRAME_MASK;
				end
				if (tick_cnt >= low_ticks()) begin
					bit_cnt++;
					tx_word = (tx_word << 1) & FRAME_MASK;
					if (bit_cnt >= FRAME_BITS) begin
						if (keep_reply)
							reply_word = rx_word[15:0];
						keep_reply = 1'b0;
						tick_cnt = 1;
						if (read_after_cmd) begin
							read_after_cmd = 1'b0;
							eng_phase = PH_GAP;
						end else begin
							eng_phase = PH_IDLE;
							tick_cnt = 0;
							done = 1'b1;
						end
					end else begin
						eng_phase = PH_HIGH;
						tick_cnt = 1;
					end
				end else begin
					tick_cnt++;
				end
			end
			PH_GAP: begin
				// chip select high for one high-phase length
				if (tick_cnt >= high_ticks())
					load_frame(ALL_ONES_WORD, 1'b1);
				else
					tick_cnt++;
			end
		endcase
		if (tick_cnt > 255)
			tick_cnt = 255;

		shifting = (eng_phase == PH_HIGH) || (eng_phase == PH_LOW);
		r.sck = (eng_phase == PH_HIGH);
		r.mosi = shifting ? tx_word[FRAME_BITS-1] : 1'b0;
		r.cs_n = !shifting;
		r.busy_res = (eng_phase != PH_IDLE);
		r.done_res = done;
		r.read_data = reply_word;
		return r;
	endfunction

	task automatic report_mismatch(string msg);
		$display("%0t ns: result word %0d: %s", $time, word_index, msg);
		mismatch_total++;
	endtask

	task automatic compare_word(gdspi_res_t got, gdspi_res_t want);
		if (got.sck !== want.sck)
			report_mismatch($sformatf("sck got %0b, expected %0b", got.sck, want.sck));
		if (got.mosi !== want.mosi)
			report_mismatch($sformatf("mosi got %0b, expected %0b", got.mosi, want.mosi));
		if (got.cs_n !== want.cs_n)
			report_mismatch($sformatf("cs_n got %0b, expected %0b", got.cs_n, want.cs_n));
		if (got.busy_res !== want.busy_res)
			report_mismatch($sformatf("busy_res got %0b, expected %0b",
				got.busy_res, want.busy_res));
		if (got.done_res !== want.done_res)
			report_mismatch($sformatf("done_res got %0b, expected %0b",
				got.done_res, want.done_res));
		if (got.read_data !== want.read_data)
			report_mismatch($sformatf("read_data got %04h, expected %04h",
				got.read_data, want.read_data));
	endtask

	// Sample both channels and the config port at each edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eng_phase = PH_IDLE;
			tick_cnt = 0;
			bit_cnt = 0;
			tx_word = '0;
			rx_word = '0;
			miso_hist = '0;
			read_after_cmd = 1'b0;
			keep_reply = 1'b0;
			reply_word = '0;
			half_period = HALF_PERIOD_RESET;
			expected_pins.delete();
			pending <= 0;
			engine_busy <= 1'b0;
		end else begin
			if (cfg_we)
				half_period = cfg_wdata;
			// results first: a word accepted now cannot be answered at this edge
			if (out_valid && !out_stall) begin
				if (expected_pins.size() == 0)
					report_mismatch("result word with nothing expected");
				else
					compare_word({sck, mosi, cs_n, busy_res, done_res, read_data},
						expected_pins.pop_front());
				word_index++;
			end
			if (in_valid && !in_stall)
				expected_pins.push_back(step_engine({operation, reg_addr, write_data, miso}));
			pending <= expected_pins.size();
			engine_busy <= (eng_phase != PH_IDLE);
		end
		fail_count <= mismatch_total;
	end

endmodule

FILE: dv/gate_driver_spi_register_master_top_tb.sv
`timescale 1ns / 100ps

module gate_driver_spi_register_master_top_tb;
	import gdspi_pkg::*;

	localparam int         FRAME_BITS = 16;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef enum int {MISO_RANDOM, MISO_SLOW, MISO_LOW, MISO_HIGH} miso_mode_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [7:0]  cfg_wdata = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  operation = OP_NONE;
	logic [3:0]  reg_addr = '0;
	logic [10:0] write_data = '0;
	logic        miso = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        sck;
	logic        mosi;
	logic        cs_n;
	logic        busy_res;
	logic        done_res;
	logic [15:0] read_data;

	int          fail_count;
	int          pending;
	logic        engine_busy;

	miso_mode_t  miso_mode = MISO_RANDOM;
	logic        miso_level = 1'b0;
	logic        gaps_on = 1'b0;
	logic        calm = 1'b0;
	int          stall_left = 0;
	int          quiet_left = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	gate_driver_spi_register_master_top #(.FRAME_BITS(FRAME_BITS)) DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.operation  (operation),
		.reg_addr   (reg_addr),
		.write_data (write_data),
		.miso       (miso),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.sck        (sck),
		.mosi       (mosi),
		.cs_n       (cs_n),
		.busy_res   (busy_res),
		.done_res   (done_res),
		.read_data  (read_data)
	);

	gdspi_pin_checker #(.FRAME_BITS(FRAME_BITS)) pin_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.operation   (operation),
		.reg_addr    (reg_addr),
		.write_data  (write_data),
		.miso        (miso),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.sck         (sck),
		.mosi        (mosi),
		.cs_n        (cs_n),
		.busy_res    (busy_res),
		.done_res    (done_res),
		.read_data   (read_data),
		.fail_count  (fail_count),
		.pending     (pending),
		.engine_busy (engine_busy)
	);

	// Output-side stalls: bursts of random length, with quiet stretches
	always @(posedge clk) begin
		if (calm) begin
			stall_left = 0;
			out_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (quiet_left > 0) begin
			quiet_left--;
			out_stall <= 1'b0;
		end else if ($urandom_range(0, 299) == 0) begin
			quiet_left = $urandom_range(50, 300);
			out_stall <= 1'b0;
		end else if ($urandom_range(0, 9) == 0) begin
			stall_left = $urandom_range(0, 12);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// One tick word: optional gap, then hold until accepted
	task automatic push_tick(logic [1:0] op, logic [3:0] addr, logic [10:0] data);
		int gap;
		if (gaps_on && !calm && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 13);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		case (miso_mode)
			MISO_RANDOM: miso_level = 1'($urandom_range(0, 1));
			MISO_SLOW: begin
				if ($urandom_range(0, 5) == 0)
					miso_level = ~miso_level;
			end
			MISO_LOW: miso_level = 1'b0;
			MISO_HIGH: miso_level = 1'b1;
		endcase
		in_valid <= 1'b1;
		operation <= op;
		reg_addr <= addr;
		write_data <= data;
		miso <= miso_level;
		do @(posedge clk); while (in_stall);
	endtask

	// Filler ticks until the engine has gone busy and back to idle;
	// the odd request slipped in while busy must be dropped
	task automatic tick_until_idle();
		logic       seen_busy;
		logic [1:0] op;
		seen_busy = 1'b0;
		do begin
			op = OP_NONE;
			if ($urandom_range(0, 11) == 0) begin
				case ($urandom_range(0, 2))
					0: op = OP_READ;
					1: op = OP_WRITE;
					default: op = OP_UNUSED;
				endcase
			end
			push_tick(op, 4'($urandom), 11'($urandom));
			if (engine_busy)
				seen_busy = 1'b1;
		end while (!seen_busy || engine_busy);
	endtask

	// Bring the engine to idle and drain all result words
	task automatic settle_engine();
		in_valid <= 1'b0;
		@(posedge clk);
		while (engine_busy) begin
			push_tick(OP_NONE, 4'd0, 11'd0);
			in_valid <= 1'b0;
			@(posedge clk);
		end
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_half_period(logic [7:0] ticks);
		settle_engine();
		cfg_we <= 1'b1;
		cfg_wdata <= ticks;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Mostly whole requests with random content, some stray idle-time words
	task automatic random_phase(logic [7:0] ticks, int n_req);
		int         issued;
		int         pick;
		logic [3:0] addr;
		set_half_period(ticks);
		issued = 0;
		while (issued < n_req) begin
			gaps_on = ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 4) == 0)
				miso_mode = $urandom_range(0, 1) ? MISO_HIGH : MISO_LOW;
			else
				miso_mode = $urandom_range(0, 1) ? MISO_RANDOM : MISO_SLOW;
			pick = $urandom_range(0, 19);
			addr = ($urandom_range(0, 7) == 0) ? 4'd0 : 4'($urandom_range(1, 15));
			if (pick < 2) begin
				push_tick((pick == 0) ? OP_UNUSED : OP_NONE, 4'($urandom), 11'($urandom));
			end else begin
				push_tick((pick < 11) ? OP_READ : OP_WRITE, addr, 11'($urandom));
				tick_until_idle();
				issued++;
			end
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset half period: read of address 0 sends only the all-ones frame
		miso_mode = MISO_HIGH;
		push_tick(OP_READ, 4'd0, 11'd0);
		tick_until_idle();

		// half period zero: one-tick high phase; read with command frame and gap
		set_half_period(8'd0);
		miso_mode = MISO_LOW;
		push_tick(OP_READ, 4'hF, 11'h7FF);
		tick_until_idle();

		// unused code and plain idle words start nothing
		push_tick(OP_UNUSED, 4'hA, 11'h2AA);
		push_tick(OP_NONE, 4'h5, 11'h555);
		push_tick(OP_UNUSED, 4'h0, 11'h000);

		// short half period: low phase stretched for the three samples
		set_half_period(8'd1);
		gaps_on = 1'b1;
		miso_mode = MISO_RANDOM;
		push_tick(OP_WRITE, 4'h8, 11'h400);
		tick_until_idle();

		// back-to-back requests: the later two land while busy
		push_tick(OP_WRITE, 4'h5, 11'h155);
		push_tick(OP_READ, 4'h9, 11'h000);
		push_tick(OP_WRITE, 4'hA, 11'h2AA);
		tick_until_idle();

		set_half_period(8'd3);
		miso_mode = MISO_SLOW;
		push_tick(OP_READ, 4'h0, 11'h000);
		tick_until_idle();

		// closing stretch with no idling on either side
		calm <= 1'b1;
		random_phase(8'd2, 2);

		in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		if (fail_count == 0)
			$display("gate_driver_spi_register_master_top_tb: PASS");
		else
			$display("gate_driver_spi_register_master_top_tb: FAIL");
		$finish;
	end

	// Watchdog
	initial begin
		#2_000_000;
		$display("gate_driver_spi_register_master_top_tb: FAIL");
		$finish;
	end

endmodule
